FILE: hw/rtl/asq_pkg.sv
// Shared types, constants and helpers of the acknowledged send queue.
package asq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int BURST_MAX   = 16;
  localparam int NWORDS      = 6;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int BCNT_W = $clog2(BURST_MAX + 1);
  localparam int LIM_W  = 5;
  localparam int OCC_W  = 6;

  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] STAT_QUEUED  = 3'd0;
  localparam logic [2:0] STAT_DROPPED = 3'd1;
  localparam logic [2:0] STAT_EMITTED = 3'd2;
  localparam logic [2:0] STAT_NONE    = 3'd3;
  localparam logic [2:0] STAT_ACKED   = 3'd4;
  localparam logic [2:0] STAT_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;
    logic [31:0] ack_sequence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      seq_out;
    logic [1:0]       kind_out;
    logic [31:0]      out0;
    logic [31:0]      out1;
    logic [31:0]      out2;
    logic [31:0]      out3;
    logic [31:0]      out4;
    logic [31:0]      out5;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } out_item_t;

  // One ring entry: sequence, kind and payload words side by side.
  typedef struct packed {
    logic [31:0]                seq;
    logic [1:0]                 kind;
    logic [NWORDS-1:0][31:0]    words;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  // Ring index plus an offset below the depth, wrapped into the ring.
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] idx,
                                                 logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {1'b0, off};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/asq_store.sv
// Ring entry memory: one write port, one read port, registered read data.
module asq_store (
  input  logic              clk_i,
  input  asq_pkg::mem_req_t req_i,
  input  asq_pkg::entry_t   wr_data_i,
  output asq_pkg::entry_t   rd_data_o
);

  asq_pkg::entry_t mem [asq_pkg::QUEUE_DEPTH];
  asq_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hw/rtl/acked_send_queue.sv
// Top level of the acknowledged send queue: control sequencer around the ring memory.
// Enqueue, clear, and a tick or ack on an empty ring answer in the cycle after accept,
// with busy kept low, so such items can follow back to back. An ack pops head entries in
// turn and a tick walks the held entries in turn, since the single read port of the ring
// memory delivers one entry per cycle. Busy drops with the final result; the receiver
// cannot stall, so nothing backs up. Reset (async, active low) empties the ring, zeroes
// the ack, sets next sequence 1, emit_limit 16; ring data is kept.
module acked_send_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  asq_pkg::in_item_t          in_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [asq_pkg::LIM_W-1:0]  cfg_data_i,
  output logic                       res_strobe_o,
  output asq_pkg::out_item_t         result_o
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACK_CK = 2'd1;
  localparam logic [1:0] S_TK_CK  = 2'd2;
  localparam logic [1:0] S_TK_FIN = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [asq_pkg::IDX_W-1:0]     head_q, head_d;
  logic [asq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [31:0]                   next_seq_q, next_seq_d;
  logic [31:0]                   acked_q, acked_d;
  logic [asq_pkg::LIM_W-1:0]     limit_q;
  logic [asq_pkg::IDX_W-1:0]     walk_q, walk_d;
  logic [asq_pkg::BCNT_W-1:0]    emit_cnt_q, emit_cnt_d;
  logic                          pend_vld_q, pend_vld_d;
  asq_pkg::entry_t               pend_q, pend_d;
  logic                          strobe_q, strobe_d;
  asq_pkg::out_item_t            res_q, res_d;

  asq_pkg::mem_req_t             mem_req;
  asq_pkg::entry_t               wr_entry;
  asq_pkg::entry_t               rd_entry;

  logic                          accept;
  logic [asq_pkg::BCNT_W-1:0]    lim_eff;
  logic                          eligible;
  logic                          walk_done;

  // Build one result item.
  function automatic asq_pkg::out_item_t mk_res(logic [2:0] status, logic [31:0] seq,
                                                asq_pkg::entry_t ent, logic with_rec,
                                                logic [asq_pkg::CNT_W-1:0] occ,
                                                logic last);
    asq_pkg::out_item_t r;
    r.status    = status;
    r.seq_out   = seq;
    r.kind_out  = with_rec ? ent.kind     : 2'd0;
    r.out0      = with_rec ? ent.words[0] : 32'd0;
    r.out1      = with_rec ? ent.words[1] : 32'd0;
    r.out2      = with_rec ? ent.words[2] : 32'd0;
    r.out3      = with_rec ? ent.words[3] : 32'd0;
    r.out4      = with_rec ? ent.words[4] : 32'd0;
    r.out5      = with_rec ? ent.words[5] : 32'd0;
    r.occupancy = asq_pkg::OCC_W'(occ);
    r.last      = last;
    return r;
  endfunction

  asq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .wr_data_i (wr_entry),
    .rd_data_o (rd_entry)
  );

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Clamp the burst limit: zero acts as one, anything past the burst maximum saturates.
  always_comb begin
    if (limit_q == '0) begin
      lim_eff = asq_pkg::BCNT_W'(1);
    end else if (limit_q > asq_pkg::LIM_W'(asq_pkg::BURST_MAX)) begin
      lim_eff = asq_pkg::BCNT_W'(asq_pkg::BURST_MAX);
    end else begin
      lim_eff = asq_pkg::BCNT_W'(limit_q);
    end
  end

  // Enqueue writes the whole record in one go.
  assign wr_entry.seq      = next_seq_q;
  assign wr_entry.kind     = in_i.kind;
  assign wr_entry.words[0] = in_i.word0;
  assign wr_entry.words[1] = in_i.word1;
  assign wr_entry.words[2] = in_i.word2;
  assign wr_entry.words[3] = in_i.word3;
  assign wr_entry.words[4] = in_i.word4;
  assign wr_entry.words[5] = in_i.word5;

  assign eligible  = (rd_entry.seq > acked_q);
  assign walk_done = ({1'b0, walk_q} + 1'b1) == (asq_pkg::IDX_W+1)'(count_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    next_seq_d = next_seq_q;
    acked_d    = acked_q;
    walk_d     = walk_q;
    emit_cnt_d = emit_cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    mem_req    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.op)
            asq_pkg::OP_ENQ: begin
              strobe_d = 1'b1;
              if (count_q >= asq_pkg::CNT_W'(asq_pkg::QUEUE_DEPTH)) begin
                // Ring full: drop the item, sequence counter holds.
                res_d = mk_res(asq_pkg::STAT_DROPPED, 32'd0, pend_q, 1'b0, count_q, 1'b1);
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = asq_pkg::slot_add(head_q, count_q[asq_pkg::IDX_W-1:0]);
                next_seq_d      = next_seq_q + 32'd1;
                count_d         = count_q + 1'b1;
                res_d = mk_res(asq_pkg::STAT_QUEUED, next_seq_q, pend_q, 1'b0,
                               count_d, 1'b1);
              end
            end
            asq_pkg::OP_TICK: begin
              walk_d     = '0;
              emit_cnt_d = '0;
              pend_vld_d = 1'b0;
              if (count_q == '0) begin
                strobe_d = 1'b1;
                res_d = mk_res(asq_pkg::STAT_NONE, 32'd0, pend_q, 1'b0, count_q, 1'b1);
              end else begin
                // Fetch the head entry; the walk starts next cycle.
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = head_q;
                state_d         = S_TK_CK;
              end
            end
            asq_pkg::OP_ACK: begin
              acked_d = in_i.ack_sequence;
              if (count_q == '0) begin
                strobe_d = 1'b1;
                res_d = mk_res(asq_pkg::STAT_ACKED, 32'd0, pend_q, 1'b0, count_q, 1'b1);
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = head_q;
                state_d         = S_ACK_CK;
              end
            end
            asq_pkg::OP_CLEAR: begin
              head_d   = '0;
              count_d  = '0;
              acked_d  = '0;
              strobe_d = 1'b1;
              res_d = mk_res(asq_pkg::STAT_CLEARED, 32'd0, pend_q, 1'b0, '0, 1'b1);
            end
            default: begin
            end
          endcase
        end
      end

      S_ACK_CK: begin
        // Pop the head while it is covered by the ack; one entry per cycle.
        if (rd_entry.seq <= acked_q) begin
          head_d  = asq_pkg::slot_add(head_q, asq_pkg::IDX_W'(1));
          count_d = count_q - 1'b1;
          if (count_d == '0) begin
            strobe_d = 1'b1;
            res_d    = mk_res(asq_pkg::STAT_ACKED, 32'd0, pend_q, 1'b0, count_d, 1'b1);
            state_d  = S_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = head_d;
          end
        end else begin
          strobe_d = 1'b1;
          res_d    = mk_res(asq_pkg::STAT_ACKED, 32'd0, pend_q, 1'b0, count_q, 1'b1);
          state_d  = S_IDLE;
        end
      end

      S_TK_CK: begin
        // Hold one found record back so the final one can carry the last mark.
        if (eligible && (emit_cnt_q == lim_eff)) begin
          state_d = S_TK_FIN;
        end else begin
          if (eligible) begin
            if (pend_vld_q) begin
              strobe_d = 1'b1;
              res_d = mk_res(asq_pkg::STAT_EMITTED, pend_q.seq, pend_q, 1'b1, count_q, 1'b0);
            end
            pend_d     = rd_entry;
            pend_vld_d = 1'b1;
            emit_cnt_d = emit_cnt_q + 1'b1;
          end
          if (walk_done) begin
            state_d = S_TK_FIN;
          end else begin
            walk_d          = walk_q + 1'b1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = asq_pkg::slot_add(head_q, walk_d);
          end
        end
      end

      S_TK_FIN: begin
        strobe_d = 1'b1;
        state_d  = S_IDLE;
        if (pend_vld_q) begin
          res_d = mk_res(asq_pkg::STAT_EMITTED, pend_q.seq, pend_q, 1'b1, count_q, 1'b1);
        end else begin
          res_d = mk_res(asq_pkg::STAT_NONE, 32'd0, pend_q, 1'b0, count_q, 1'b1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      next_seq_q <= 32'd1;
      acked_q    <= '0;
      limit_q    <= asq_pkg::LIM_W'(16);
      walk_q     <= '0;
      emit_cnt_q <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      next_seq_q <= next_seq_d;
      acked_q    <= acked_d;
      walk_q     <= walk_d;
      emit_cnt_q <= emit_cnt_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign result_o     = res_q;

endmodule

FILE: hw/rtl/asq_chk.sv
// Port-level checker of the acknowledged send queue, bound to the top level.
module asq_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               res_strobe_o,
  input asq_pkg::out_item_t result_o
);

  // Only emitted records can be followed by more results of the same item.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (result_o.status != asq_pkg::STAT_EMITTED) |-> result_o.last)
    else $error("non-emit result without last mark");

  // A clear always leaves the ring empty.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (result_o.status == asq_pkg::STAT_CLEARED) |-> result_o.occupancy == '0)
    else $error("clear left records behind");

  // A drop only happens on a full ring.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (result_o.status == asq_pkg::STAT_DROPPED)
      |-> result_o.occupancy == asq_pkg::OCC_W'(asq_pkg::QUEUE_DEPTH))
    else $error("drop reported on a ring with room");

  // An idle block with no new item produces no result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !res_strobe_o)
    else $error("result strobe without a pending item");

endmodule

bind acked_send_queue asq_chk u_asq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .result_o     (result_o)
);

FILE: test/tb.sv
// Self-checking testbench for the acknowledged send queue, with a ring predictor and random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no accepted item, result or register write before the run is abandoned.
  // The slowest step is a tick over a full ring; gaps and drains are shorter.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  asq_pkg::in_item_t         cmd_bus;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [asq_pkg::LIM_W-1:0] cfg_data_i;
  logic                      res_strobe_o;
  asq_pkg::out_item_t        result_o;

  acked_send_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (cmd_bus),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------------
  // Ring predictor: a private copy of the queue state, advanced once per accepted item.
  // Only slots inside the held window are ever read, so stale slot contents never matter.
  // ---------------------------------------------------------------------------------------------
  asq_pkg::entry_t           ring_slot [asq_pkg::QUEUE_DEPTH];
  int unsigned               ring_head;
  int unsigned               ring_count;
  logic [31:0]               seq_next;
  logic [31:0]               seq_acked;
  logic [asq_pkg::LIM_W-1:0] limit_reg;

  // Results the block still owes, oldest first.
  asq_pkg::out_item_t        ring_results_due [$];

  // Bookkeeping for the checker, the sender and the closing summary.
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen   = 0;
  int unsigned      items_sent     = 0;
  int unsigned      limits_written = 0;
  int unsigned      status_tally [8];
  int unsigned      burst_left     = 0;
  int unsigned      quiet_cycles   = 0;

  // Work out every result one item causes and append them to ring_results_due.
  function automatic void compute_ring_results(asq_pkg::in_item_t it);
    asq_pkg::out_item_t r;
    int unsigned        slot;
    int unsigned        burst_cap;
    int unsigned        emit_slots [$];
    r      = '0;
    r.last = 1'b1;
    case (it.op)
      asq_pkg::OP_ENQ: begin
        if (ring_count >= asq_pkg::QUEUE_DEPTH) begin
          // Full ring: drop the record, keep the sequence counter where it is.
          r.status = asq_pkg::STAT_DROPPED;
        end else begin
          slot                  = (ring_head + ring_count) % asq_pkg::QUEUE_DEPTH;
          ring_slot[slot].seq   = seq_next;
          ring_slot[slot].kind  = it.kind;
          ring_slot[slot].words = {it.word5, it.word4, it.word3, it.word2, it.word1, it.word0};
          r.status              = asq_pkg::STAT_QUEUED;
          r.seq_out             = seq_next;
          seq_next              = seq_next + 32'd1;  // wraps modulo 2^32
          ring_count++;
        end
        r.occupancy = asq_pkg::OCC_W'(ring_count);
        ring_results_due.push_back(r);
      end
      asq_pkg::OP_TICK: begin
        // Clamp the register: zero acts as one, anything above the burst size as the burst size.
        if (limit_reg == '0) begin
          burst_cap = 1;
        end else if (limit_reg > asq_pkg::BURST_MAX) begin
          burst_cap = asq_pkg::BURST_MAX;
        end else begin
          burst_cap = limit_reg;
        end
        // Walk from the head; skip records already covered by the ack, they use no budget.
        for (int i = 0; i < ring_count; i++) begin
          slot = (ring_head + i) % asq_pkg::QUEUE_DEPTH;
          if (ring_slot[slot].seq > seq_acked && emit_slots.size() < burst_cap) begin
            emit_slots.push_back(slot);
          end
        end
        r.occupancy = asq_pkg::OCC_W'(ring_count);
        if (emit_slots.size() == 0) begin
          r.status = asq_pkg::STAT_NONE;
          ring_results_due.push_back(r);
        end else begin
          foreach (emit_slots[k]) begin
            r.status   = asq_pkg::STAT_EMITTED;
            r.seq_out  = ring_slot[emit_slots[k]].seq;
            r.kind_out = ring_slot[emit_slots[k]].kind;
            r.out0     = ring_slot[emit_slots[k]].words[0];
            r.out1     = ring_slot[emit_slots[k]].words[1];
            r.out2     = ring_slot[emit_slots[k]].words[2];
            r.out3     = ring_slot[emit_slots[k]].words[3];
            r.out4     = ring_slot[emit_slots[k]].words[4];
            r.out5     = ring_slot[emit_slots[k]].words[5];
            r.last     = (k == emit_slots.size() - 1);
            ring_results_due.push_back(r);
          end
        end
      end
      asq_pkg::OP_ACK: begin
        // Overwrite the ack, then pop head records at or below it.
        seq_acked = it.ack_sequence;
        while (ring_count > 0 && ring_slot[ring_head].seq <= seq_acked) begin
          ring_head = (ring_head + 1) % asq_pkg::QUEUE_DEPTH;
          ring_count--;
        end
        r.status    = asq_pkg::STAT_ACKED;
        r.occupancy = asq_pkg::OCC_W'(ring_count);
        ring_results_due.push_back(r);
      end
      asq_pkg::OP_CLEAR: begin
        // Empty the ring and zero the ack; the sequence counter runs on.
        ring_head  = 0;
        ring_count = 0;
        seq_acked  = '0;
        r.status   = asq_pkg::STAT_CLEARED;
        ring_results_due.push_back(r);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Result checker: compare each strobed result with the oldest one still owed.
  // ---------------------------------------------------------------------------------------------
  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, field, want, got);
      end
    end
  endtask

  task automatic check_ring_result(asq_pkg::out_item_t got);
    asq_pkg::out_item_t want;
    results_seen++;
    if (ring_results_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: result with nothing expected: status %0d seq 0x%08h",
                 $time, got.status, got.seq_out);
      end
    end else begin
      want = ring_results_due.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("seq_out", want.seq_out, got.seq_out);
      compare_field("kind_out", 32'(want.kind_out), 32'(got.kind_out));
      compare_field("out0", want.out0, got.out0);
      compare_field("out1", want.out1, got.out1);
      compare_field("out2", want.out2, got.out2);
      compare_field("out3", want.out3, got.out3);
      compare_field("out4", want.out4, got.out4);
      compare_field("out5", want.out5, got.out5);
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      compare_field("last", 32'(want.last), 32'(got.last));
      status_tally[want.status]++;
    end
  endtask

  // Sample at the rising edge: result ports still hold the values of the closing cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      check_ring_result(result_o);
    end
  end

  // Watchdog: abandon the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: timeout after %0d quiet cycles, %0d results still owed",
               $time, quiet_cycles, ring_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sender side. Drive at the falling edge, watch the handshake at the rising edge.
  // start stays high across back-to-back items; only a pause or a drain lowers it.
  // ---------------------------------------------------------------------------------------------

  // Drop start and hold off for the given number of cycles (at least one).
  task automatic pause_sender(int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Offer one item and hold it until the block takes it; work in bursts with random gaps.
  task automatic push_command(asq_pkg::in_item_t it);
    if (burst_left == 0) begin
      // About a third of the bursts follow the previous one back to back.
      if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 10));
      end
      // Now and then run a long stretch with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    start   <= 1'b1;
    cmd_bus <= it;
    do @(posedge clk_i); while (busy);
    compute_ring_results(it);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result has come and the block has settled.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    // The sequencer is already idle by its last strobe; the extra wait only adds margin.
    repeat (4) @(posedge clk_i);
  endtask

  // Write emit_limit while the block is idle.
  task automatic set_emit_limit(logic [asq_pkg::LIM_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg = value;
    limits_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Item with the given op and random content in every other field.
  function automatic asq_pkg::in_item_t random_command(logic [1:0] op);
    asq_pkg::in_item_t it;
    it.op           = op;
    it.kind         = 2'($urandom_range(0, 3));
    it.word0        = $urandom();
    it.word1        = $urandom();
    it.word2        = $urandom();
    it.word3        = $urandom();
    it.word4        = $urandom();
    it.word5        = $urandom();
    it.ack_sequence = $urandom();
    return it;
  endfunction

  // Ack value: mostly just behind the newest sequence, so acks pop none, some or all held
  // records; sometimes far ahead (hides the ring from ticks) or behind the current ack.
  function automatic logic [31:0] pick_ack();
    logic [31:0] newest;
    newest = seq_next - 32'd1;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, seq_acked);
      default: return newest - $urandom_range(0, (newest < 40) ? newest : 40);
    endcase
  endfunction

  // Random mix of operations by percentage; the remainder are clears.
  task automatic run_traffic(int unsigned n, int unsigned enq_pct, int unsigned tick_pct,
                             int unsigned ack_pct);
    asq_pkg::in_item_t it;
    int unsigned       roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        it = random_command(asq_pkg::OP_ENQ);
      end else if (roll < enq_pct + tick_pct) begin
        it = random_command(asq_pkg::OP_TICK);
      end else if (roll < enq_pct + tick_pct + ack_pct) begin
        it              = random_command(asq_pkg::OP_ACK);
        it.ack_sequence = pick_ack();
      end else begin
        it = random_command(asq_pkg::OP_CLEAR);
      end
      push_command(it);
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Every op once or more, payload extremes, ack extremes, skipped records and clear.
  task automatic test_basic_ops();
    asq_pkg::in_item_t it;
    // Tick and ack on an empty ring.
    push_command(random_command(asq_pkg::OP_TICK));
    it              = random_command(asq_pkg::OP_ACK);
    it.ack_sequence = '0;
    push_command(it);
    // All-zero record with kind 0, then all-ones record with kind 3.
    it    = '0;
    it.op = asq_pkg::OP_ENQ;
    push_command(it);
    it    = '1;
    it.op = asq_pkg::OP_ENQ;
    push_command(it);
    repeat (2) push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_TICK));
    // Pop just the oldest record, then emit the rest again.
    it              = random_command(asq_pkg::OP_ACK);
    it.ack_sequence = seq_next - 32'd4;
    push_command(it);
    push_command(random_command(asq_pkg::OP_TICK));
    // Ack the top of the range: pop everything.
    it.ack_sequence = '1;
    push_command(it);
    // A record queued now sits at or below the ack: the tick skips it and finds nothing.
    push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_TICK));
    // Lower the ack back to zero: the record shows up again.
    it.ack_sequence = '0;
    push_command(it);
    push_command(random_command(asq_pkg::OP_TICK));
    // Clear keeps the sequence counter running.
    repeat (2) push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_CLEAR));
    push_command(random_command(asq_pkg::OP_TICK));
    push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_TICK));
    drain_results();
  endtask

  // Sweep emit_limit over its extremes and out-of-range values, ticking a well-stocked ring.
  task automatic test_emit_limits();
    logic [asq_pkg::LIM_W-1:0] sweep [7];
    asq_pkg::in_item_t         it;
    sweep    = '{5'd1, 5'd0, 5'd2, 5'd17, 5'd31, 5'd16, 5'd0};
    sweep[6] = asq_pkg::LIM_W'($urandom_range(3, 15));
    foreach (sweep[s]) begin
      set_emit_limit(sweep[s]);
      repeat ($urandom_range(8, 20)) push_command(random_command(asq_pkg::OP_ENQ));
      repeat (2) push_command(random_command(asq_pkg::OP_TICK));
      it              = random_command(asq_pkg::OP_ACK);
      it.ack_sequence = pick_ack();
      push_command(it);
      push_command(random_command(asq_pkg::OP_TICK));
    end
  endtask

  // Fill the ring past its depth, then ack in two steps around a wrapped head.
  task automatic test_ring_overflow();
    asq_pkg::in_item_t it;
    push_command(random_command(asq_pkg::OP_CLEAR));
    // The last three enqueues find the ring full and are dropped.
    repeat (asq_pkg::QUEUE_DEPTH + 3) push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_TICK));
    // Hold the sender until the full-ring results are all in.
    drain_results();
    it              = random_command(asq_pkg::OP_ACK);
    it.ack_sequence = seq_next - 32'd17;
    push_command(it);
    repeat (8) push_command(random_command(asq_pkg::OP_ENQ));
    push_command(random_command(asq_pkg::OP_TICK));
    it.ack_sequence = seq_next - 32'd1;
    push_command(it);
    push_command(random_command(asq_pkg::OP_TICK));
  endtask

  // Random traffic in phases with different op mixes and random emit_limit settings.
  task automatic test_random_traffic();
    set_emit_limit(asq_pkg::LIM_W'($urandom_range(0, 31)));
    run_traffic(45, 45, 20, 30);
    // Enqueue-heavy: reach the full ring often.
    set_emit_limit(asq_pkg::LIM_W'($urandom_range(0, 31)));
    run_traffic(45, 70, 15, 12);
    set_emit_limit(asq_pkg::LIM_W'($urandom_range(0, 31)));
    run_traffic(45, 30, 35, 30);
    // Pause mid-phase until every owed result has come.
    set_emit_limit(asq_pkg::LIM_W'($urandom_range(1, 16)));
    run_traffic(22, 50, 25, 20);
    drain_results();
    run_traffic(23, 50, 25, 20);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_bus     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    ring_head   = 0;
    ring_count  = 0;
    seq_next    = 32'd1;
    seq_acked   = '0;
    limit_reg   = asq_pkg::LIM_W'(asq_pkg::BURST_MAX);
    foreach (status_tally[i]) status_tally[i] = 0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_emit_limits();
    test_ring_overflow();
    test_random_traffic();
    drain_results();

    $display("Sent %0d items, checked %0d results: %0d queued, %0d dropped, %0d emitted,",
             items_sent, results_seen, status_tally[asq_pkg::STAT_QUEUED],
             status_tally[asq_pkg::STAT_DROPPED], status_tally[asq_pkg::STAT_EMITTED]);
    $display("%0d empty ticks, %0d acks, %0d clears; emit_limit written %0d times incl. 0, 31",
             status_tally[asq_pkg::STAT_NONE], status_tally[asq_pkg::STAT_ACKED],
             status_tally[asq_pkg::STAT_CLEARED], limits_written);
    if (mismatch_count == 0 && ring_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, ring_results_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: acked_send_queue.f
hw/rtl/asq_pkg.sv
hw/rtl/asq_store.sv
hw/rtl/acked_send_queue.sv
hw/rtl/asq_chk.sv
test/tb.sv
